// ===== sv/plid_pkg.sv =====
// package for the pair list insert/dedup unit: beat types, command and status codes,
// cell control struct and width constants
// no dependencies
package plid_pkg;

  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned CNT_MAX_W = 13;

  localparam int unsigned CAPACITY_DEFAULT    = 64;
  localparam int unsigned VALUE_WIDTH_DEFAULT = 16;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_DUP   = 2'd1,
    STS_RANGE = 2'd2,
    STS_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_COMMIT = 2'b10
  } state_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [POS_W-1:0]   position;
    logic [FIELD_W-1:0] first_value;
    logic [FIELD_W-1:0] second_value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [POS_W-1:0]   entry_count;
    logic [FIELD_W-1:0] read_first;
    logic [FIELD_W-1:0] read_second;
  } out_beat_t;

  typedef struct packed {
    logic                 eval;
    logic                 wr_app;
    logic                 wr_ins;
    logic [CNT_MAX_W-1:0] pos;
    logic [CNT_MAX_W-1:0] count;
    logic [FIELD_W-1:0]   first_val;
    logic [FIELD_W-1:0]   second_val;
  } cell_ctl_t;

endpackage

// ===== sv/plid_cell.sv =====
// one list slot of the pair list: stored pair, duplicate match flag, read select
// shifts up from its lower neighbor on insert; depends on plid_pkg
module plid_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned SW  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plid_pkg::cell_ctl_t ctl_i,
  input  logic [SW-1:0]       prev_first_i,
  input  logic [SW-1:0]       prev_second_i,
  output logic [SW-1:0]       first_o,
  output logic [SW-1:0]       second_o,
  output logic                match_o,
  output logic [SW-1:0]       rd_first_o,
  output logic [SW-1:0]       rd_second_o
);
  import plid_pkg::*;

  localparam logic [CNT_MAX_W-1:0] IDX_C = CNT_MAX_W'(IDX);

  logic [SW-1:0] first_q, first_d;
  logic [SW-1:0] second_q, second_d;
  logic          match_q, sel_q;
  logic          occupied;

  assign occupied = IDX_C < ctl_i.count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (ctl_i.eval) begin
      match_q <= occupied && (first_q == ctl_i.first_val[SW-1:0])
                 && (second_q == ctl_i.second_val[SW-1:0]);
      sel_q   <= (IDX_C == ctl_i.pos);
    end
  end

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    if (ctl_i.wr_app && (IDX_C == ctl_i.count)) begin
      first_d  = ctl_i.first_val[SW-1:0];
      second_d = ctl_i.second_val[SW-1:0];
    end else if (ctl_i.wr_ins) begin
      if (IDX_C == ctl_i.pos) begin
        first_d  = ctl_i.first_val[SW-1:0];
        second_d = ctl_i.second_val[SW-1:0];
      end else if ((IDX_C > ctl_i.pos) && (IDX_C <= ctl_i.count)) begin
        first_d  = prev_first_i;
        second_d = prev_second_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
  end

  assign first_o     = first_q;
  assign second_o    = second_q;
  assign match_o     = match_q;
  assign rd_first_o  = sel_q ? first_q : '0;
  assign rd_second_o = sel_q ? second_q : '0;

endmodule

// ===== sv/pair_list_insert_dedup_unit.sv =====
// top level of the pair list unit: command channel, result channel, config write
// depends on plid_pkg and plid_cell
//
// usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) carries one command beat:
//   append, insert at position or read at position
//   out channel (out_valid_o/out_ready_i/out_data_o) returns one result beat per
//   command with status, entry count after the command and read data
//   cfg channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes allow_duplicates;
//   always ready, write only while no command is in flight
// timing:
//   a command is taken in the idle state and every cell registers its duplicate
//   match and read select at that edge; in the commit state that follows, once
//   the output register is free, the status is resolved, the cells shift or load
//   and the result is registered; a new command is taken only back in idle
//   the next command is taken while a result waits; if the receiver stalls,
//   that command holds in the commit state until the output register frees
// reset:
//   count cleared, allow_duplicates set, no result pending; stored pairs are
//   not cleared
module pair_list_insert_dedup_unit #(
  parameter int unsigned CAPACITY    = plid_pkg::CAPACITY_DEFAULT,
  parameter int unsigned VALUE_WIDTH = plid_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  plid_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output plid_pkg::out_beat_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);
  import plid_pkg::*;

  localparam int unsigned SW = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_e               state_q, state_d;
  logic [1:0]           cmd_q;
  logic [POS_W-1:0]     pos_q;
  logic [FIELD_W-1:0]   first_q, second_q;
  logic [CW-1:0]        count_q, count_d;
  logic                 allow_q;
  logic                 out_valid_q;
  out_beat_t            out_q, out_d;

  logic                 accept;
  logic                 commit_go;
  logic [FIELD_W-1:0]   in_first_m, in_second_m;
  logic [CNT_MAX_W-1:0] pos_ext, count_ext;
  logic                 full;
  logic                 dup_any;
  logic [SW-1:0]        rd_first, rd_second;
  logic                 wr_app, wr_ins;
  cell_ctl_t            ctl;

  logic [SW-1:0] cell_first  [CAPACITY];
  logic [SW-1:0] cell_second [CAPACITY];
  logic [SW-1:0] cell_rd_first  [CAPACITY];
  logic [SW-1:0] cell_rd_second [CAPACITY];
  logic [CAPACITY-1:0] cell_match;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign commit_go   = (state_q == ST_COMMIT) && (!out_valid_q || out_ready_i);
  assign cfg_ready_o = 1'b1;

  assign in_first_m  = FIELD_W'(in_data_i.first_value[SW-1:0]);
  assign in_second_m = FIELD_W'(in_data_i.second_value[SW-1:0]);
  assign pos_ext     = (state_q == ST_IDLE) ? CNT_MAX_W'(in_data_i.position)
                                            : CNT_MAX_W'(pos_q);
  assign count_ext   = CNT_MAX_W'(count_q);
  assign full        = (count_q == CAP_C);

  assign ctl.eval       = accept;
  assign ctl.wr_app     = wr_app;
  assign ctl.wr_ins     = wr_ins;
  assign ctl.pos        = pos_ext;
  assign ctl.count      = count_ext;
  assign ctl.first_val  = (state_q == ST_IDLE) ? in_first_m : first_q;
  assign ctl.second_val = (state_q == ST_IDLE) ? in_second_m : second_q;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [SW-1:0] prev_first, prev_second;
    if (g == 0) begin : g_head
      assign prev_first  = '0;
      assign prev_second = '0;
    end else begin : g_link
      assign prev_first  = cell_first[g-1];
      assign prev_second = cell_second[g-1];
    end
    plid_cell #(
      .IDX (g),
      .SW  (SW)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .prev_first_i  (prev_first),
      .prev_second_i (prev_second),
      .first_o       (cell_first[g]),
      .second_o      (cell_second[g]),
      .match_o       (cell_match[g]),
      .rd_first_o    (cell_rd_first[g]),
      .rd_second_o   (cell_rd_second[g])
    );
  end

  assign dup_any = |cell_match;

  always_comb begin
    rd_first  = '0;
    rd_second = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_first  = rd_first | cell_rd_first[i];
      rd_second = rd_second | cell_rd_second[i];
    end
  end

  always_comb begin
    wr_app  = 1'b0;
    wr_ins  = 1'b0;
    count_d = count_q;
    out_d   = '0;
    out_d.status = STS_OK;
    unique case (cmd_q)
      CMD_APPEND: begin
        if (!allow_q && dup_any) begin
          out_d.status = STS_DUP;
        end else if (full) begin
          out_d.status = STS_FULL;
        end else begin
          wr_app = commit_go;
        end
      end
      CMD_INSERT: begin
        if (CNT_MAX_W'(pos_q) > count_ext) begin
          out_d.status = STS_RANGE;
        end else if (full) begin
          out_d.status = STS_FULL;
        end else begin
          wr_ins = commit_go;
        end
      end
      CMD_READ: begin
        if (CNT_MAX_W'(pos_q) >= count_ext) begin
          out_d.status = STS_RANGE;
        end else begin
          out_d.read_first  = FIELD_W'(rd_first);
          out_d.read_second = FIELD_W'(rd_second);
        end
      end
      default: begin
      end
    endcase
    if (wr_app || wr_ins) begin
      count_d = count_q + 1'b1;
    end
    out_d.entry_count = POS_W'(CNT_MAX_W'(count_d));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_COMMIT;
      ST_COMMIT: if (commit_go) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      allow_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit_go) begin
        count_q <= count_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        allow_q <= cfg_data_i;
      end
      if (commit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= in_data_i.cmd;
      pos_q    <= in_data_i.position;
      first_q  <= in_first_m;
      second_q <= in_second_m;
    end
    if (commit_go) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == CW'($past(count_q) + 1'b1)))
    else $error("entry count moved by more than one");

  a_accept_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_COMMIT))
    else $error("accepted command did not enter commit");

  a_commit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_go |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("commit did not produce a result");

  a_write_only_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_app || wr_ins) |-> commit_go)
    else $error("cell write outside commit");

endmodule
